[rtl/mfqs_pkg.sv]
// Shared types and constants for the multilevel feedback queue scheduler.
// Depends on nothing; the ring pointers, the core and the testbench import it.
package mfqs_pkg;

  localparam int PID_PORT_W = 16;
  localparam int QUANTUM_W  = 8;
  localparam int NUM_LEVELS = 3;

  // request function codes
  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_REPORT   = 2'd2;

  // response status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NONE_READY = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
  localparam logic [1:0] STATUS_NOT_RUN    = 2'd3;

  // queue levels
  localparam logic [1:0] LVL0 = 2'd0;
  localparam logic [1:0] LVL1 = 2'd1;
  localparam logic [1:0] LVL2 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [1:0] CFG_QUANTUM2 = 2'd2;

  localparam logic [QUANTUM_W-1:0] QUANTUM0_RST = 8'd1;
  localparam logic [QUANTUM_W-1:0] QUANTUM1_RST = 8'd2;
  localparam logic [QUANTUM_W-1:0] QUANTUM2_RST = 8'd4;

  typedef struct packed {
    logic [1:0]            func;
    logic [PID_PORT_W-1:0] new_pid;
    logic                  finished;
    logic                  did_io;
  } req_t;

  typedef struct packed {
    logic [PID_PORT_W-1:0] granted_pid;
    logic [1:0]            granted_level;
    logic [QUANTUM_W-1:0]  granted_quantum;
    logic [1:0]            status;
  } rsp_t;

  typedef struct packed {
    logic [1:0]           reg_idx;
    logic [QUANTUM_W-1:0] wdata;
  } cfg_t;

  // queue pointer command: one push and one pop per cycle at most
  typedef struct packed {
    logic       push;
    logic [1:0] push_lvl;
    logic       pop;
    logic [1:0] pop_lvl;
  } ptr_cmd_t;

endpackage

[rtl/mfqs_stream_if.sv]
// Valid/ready channel carrying one payload of type T per transaction.
// Used with mfqs_pkg payload types for request, response and config.
interface mfqs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mfqs_qmem.sv]
// Queue storage: single write port, single registered read port.
// Holds the rings of all levels back to back. Depends on nothing.
module mfqs_qmem #(
  parameter int DEPTH  = 96,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mfqs_ring_ptrs.sv]
// Head and occupancy registers of the three level rings; forms the memory
// addresses for the push tail and the pop head. Depends on mfqs_pkg.
module mfqs_ring_ptrs #(
  parameter int MAX_PROCS = 32,
  parameter int ADDR_W    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfqs_pkg::ptr_cmd_t  cmd_i,
  output logic [2:0]          nonempty_o,
  output logic [2:0]          full_o,
  output logic [ADDR_W-1:0]   waddr_o,
  output logic [ADDR_W-1:0]   raddr_o
);
  import mfqs_pkg::*;

  localparam int SlotW = $clog2(MAX_PROCS);
  localparam int SumW  = SlotW + 1;
  localparam int CntW  = $clog2(MAX_PROCS + 1);

  localparam logic [ADDR_W-1:0] Base1 = ADDR_W'(MAX_PROCS);
  localparam logic [ADDR_W-1:0] Base2 = ADDR_W'(2 * MAX_PROCS);
  localparam logic [SumW-1:0]   MaxSum = SumW'(MAX_PROCS);
  localparam logic [SlotW-1:0]  LastSlot = SlotW'(MAX_PROCS - 1);
  localparam logic [CntW-1:0]   MaxCnt = CntW'(MAX_PROCS);

  logic [SlotW-1:0] head_q [NUM_LEVELS];
  logic [SlotW-1:0] head_d [NUM_LEVELS];
  logic [CntW-1:0]  cnt_q  [NUM_LEVELS];
  logic [CntW-1:0]  cnt_d  [NUM_LEVELS];
  logic [SlotW-1:0] tail   [NUM_LEVELS];
  logic [SumW-1:0]  tail_sum [NUM_LEVELS];
  logic [SlotW-1:0] wslot, rslot;

  function automatic logic [ADDR_W-1:0] lvl_base(input logic [1:0] lvl);
    logic [ADDR_W-1:0] b;
    case (lvl)
      LVL1:    b = Base1;
      LVL2:    b = Base2;
      default: b = '0;
    endcase
    return b;
  endfunction

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      tail_sum[l]   = SumW'(head_q[l]) + SumW'(cnt_q[l]);
      tail[l]       = (tail_sum[l] >= MaxSum) ? SlotW'(tail_sum[l] - MaxSum)
                                              : SlotW'(tail_sum[l]);
      nonempty_o[l] = (cnt_q[l] != '0);
      full_o[l]     = (cnt_q[l] == MaxCnt);
      head_d[l]     = head_q[l];
      cnt_d[l]      = cnt_q[l];
      if (cmd_i.pop && (cmd_i.pop_lvl == 2'(l))) begin
        head_d[l] = (head_q[l] == LastSlot) ? '0 : head_q[l] + 1'b1;
      end
      if (cmd_i.push && (cmd_i.push_lvl == 2'(l)) &&
          !(cmd_i.pop && (cmd_i.pop_lvl == 2'(l)))) begin
        cnt_d[l] = cnt_q[l] + 1'b1;
      end else if (cmd_i.pop && (cmd_i.pop_lvl == 2'(l)) &&
                   !(cmd_i.push && (cmd_i.push_lvl == 2'(l)))) begin
        cnt_d[l] = cnt_q[l] - 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_i.push_lvl)
      LVL1:    wslot = tail[1];
      LVL2:    wslot = tail[2];
      default: wslot = tail[0];
    endcase
    case (cmd_i.pop_lvl)
      LVL1:    rslot = head_q[1];
      LVL2:    rslot = head_q[2];
      default: rslot = head_q[0];
    endcase
  end

  assign waddr_o = lvl_base(cmd_i.push_lvl) + ADDR_W'(wslot);
  assign raddr_o = lvl_base(cmd_i.pop_lvl) + ADDR_W'(rslot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= head_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
    end
  end

endmodule

[rtl/multilevel_feedback_queue_scheduler_core.sv]
// Top level of the three-level feedback queue scheduler.
// Depends on mfqs_pkg, mfqs_stream_if, mfqs_qmem and mfqs_ring_ptrs.
//
//   channel  dir  payload        transaction
//   req_i    in   mfqs_pkg::req_t valid & ready: add, dispatch or report
//   rsp_o    out  mfqs_pkg::rsp_t valid & ready: one response per request
//   cfg_i    in   mfqs_pkg::cfg_t valid & ready: quantum register write
//
// Response path: add, report, re-grant and refused requests load the response
// register directly; a dispatch that pops a queue first reads the ring head
// from the queue memory, whose read data is registered, and then loads it.
// Reset: asynchronous, active low; clears pointers, counters, running state
// and sets the quanta to 1, 2, 4. Queue memory contents are not cleared.
// Stalls: a request is taken only while no pop read is pending and the
// response register is empty or being drained; cfg_i is always ready.
module multilevel_feedback_queue_scheduler_core #(
  parameter int MAX_PROCS = 32,
  parameter int PID_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfqs_stream_if.sink   req_i,
  mfqs_stream_if.source rsp_o,
  mfqs_stream_if.sink   cfg_i
);
  import mfqs_pkg::*;

  // stored ids never carry more bits than the port
  localparam int PidW  = (PID_BITS < PID_PORT_W) ? PID_BITS : PID_PORT_W;
  localparam int AddrW = $clog2(3 * MAX_PROCS);
  localparam int CntW  = $clog2(MAX_PROCS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PROCS);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;

  // running process
  logic            run_valid_q, run_valid_d;
  logic [PidW-1:0] run_pid_q, run_pid_d;
  logic [1:0]      run_lvl_q, run_lvl_d;
  logic [CntW-1:0] proc_cnt_q, proc_cnt_d;
  logic [1:0]      pend_lvl_q, pend_lvl_d;

  // quantum registers
  logic [QUANTUM_W-1:0] quantum_q [NUM_LEVELS];

  // response register
  logic out_valid_q, out_valid_d;
  rsp_t out_data_q, out_data_d;
  logic out_load;

  logic     in_ready, acc;
  req_t     req;
  ptr_cmd_t cmd;
  logic [2:0]       nonempty, full;
  logic [AddrW-1:0] waddr, raddr;
  logic [PidW-1:0]  wdata, rdata;
  logic [1:0]       dest_lvl, sel_lvl;

  function automatic logic [QUANTUM_W-1:0] quantum_of(
    input logic [1:0] lvl,
    input logic [QUANTUM_W-1:0] q0,
    input logic [QUANTUM_W-1:0] q1,
    input logic [QUANTUM_W-1:0] q2
  );
    logic [QUANTUM_W-1:0] q;
    case (lvl)
      LVL1:    q = q1;
      LVL2:    q = q2;
      default: q = q0;
    endcase
    return q;
  endfunction

  assign req      = req_i.data;
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign acc      = req_i.valid && in_ready;

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;
  assign cfg_i.ready = 1'b1;

  // highest-priority non-empty level
  assign sel_lvl = nonempty[0] ? LVL0 : (nonempty[1] ? LVL1 : LVL2);

  // feedback: I/O promotes (or keeps at top), a used-up slice demotes (or keeps at bottom)
  always_comb begin
    if (req.did_io) begin
      dest_lvl = (run_lvl_q == LVL2) ? LVL1 : LVL0;
    end else begin
      dest_lvl = (run_lvl_q == LVL0) ? LVL1 : LVL2;
    end
  end

  always_comb begin
    state_d     = state_q;
    run_valid_d = run_valid_q;
    run_pid_d   = run_pid_q;
    run_lvl_d   = run_lvl_q;
    proc_cnt_d  = proc_cnt_q;
    pend_lvl_d  = pend_lvl_q;
    cmd         = '0;
    wdata       = req.new_pid[PidW-1:0];
    out_load    = 1'b0;
    out_data_d  = '0;

    if (state_q == ST_READ) begin
      // head id arrives from the memory
      state_d     = ST_IDLE;
      run_valid_d = 1'b1;
      run_pid_d   = rdata;
      run_lvl_d   = pend_lvl_q;
      out_load    = 1'b1;
      out_data_d.granted_pid     = PID_PORT_W'(rdata);
      out_data_d.granted_level   = pend_lvl_q;
      out_data_d.granted_quantum = quantum_of(pend_lvl_q, quantum_q[0],
                                              quantum_q[1], quantum_q[2]);
      out_data_d.status          = STATUS_OK;
    end else if (acc) begin
      case (req.func)
        FUNC_ADD: begin
          out_load = 1'b1;
          if (proc_cnt_q >= MaxCnt) begin
            out_data_d.status = STATUS_TABLE_FULL;
          end else begin
            cmd.push     = !full[0];
            cmd.push_lvl = LVL0;
            proc_cnt_d   = proc_cnt_q + 1'b1;
          end
        end
        FUNC_DISPATCH: begin
          if (run_valid_q) begin
            out_load = 1'b1;
            out_data_d.granted_pid     = PID_PORT_W'(run_pid_q);
            out_data_d.granted_level   = run_lvl_q;
            out_data_d.granted_quantum = quantum_of(run_lvl_q, quantum_q[0],
                                                    quantum_q[1], quantum_q[2]);
          end else if (nonempty != '0) begin
            cmd.pop     = 1'b1;
            cmd.pop_lvl = sel_lvl;
            pend_lvl_d  = sel_lvl;
            state_d     = ST_READ;
          end else begin
            out_load          = 1'b1;
            out_data_d.status = STATUS_NONE_READY;
          end
        end
        FUNC_REPORT: begin
          out_load = 1'b1;
          if (!run_valid_q) begin
            out_data_d.status = STATUS_NOT_RUN;
          end else begin
            if (req.finished) begin
              if (proc_cnt_q != '0) begin
                proc_cnt_d = proc_cnt_q - 1'b1;
              end
            end else begin
              cmd.push     = !full[dest_lvl];
              cmd.push_lvl = dest_lvl;
              wdata        = run_pid_q;
            end
            run_valid_d = 1'b0;
            run_pid_d   = '0;
            run_lvl_d   = LVL0;
          end
        end
        default: begin
          // unused function code: plain OK with zero grant
          out_load = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  mfqs_ring_ptrs #(
    .MAX_PROCS (MAX_PROCS),
    .ADDR_W    (AddrW)
  ) u_ptrs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .nonempty_o (nonempty),
    .full_o     (full),
    .waddr_o    (waddr),
    .raddr_o    (raddr)
  );

  mfqs_qmem #(
    .DEPTH  (3 * MAX_PROCS),
    .ADDR_W (AddrW),
    .DATA_W (PidW)
  ) u_qmem (
    .clk_i   (clk_i),
    .we_i    (cmd.push),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd.pop),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_valid_q <= 1'b0;
      run_pid_q   <= '0;
      run_lvl_q   <= LVL0;
      proc_cnt_q  <= '0;
      pend_lvl_q  <= LVL0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_valid_q <= run_valid_d;
      run_pid_q   <= run_pid_d;
      run_lvl_q   <= run_lvl_d;
      proc_cnt_q  <= proc_cnt_d;
      pend_lvl_q  <= pend_lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  // configuration writes; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q[0] <= QUANTUM0_RST;
      quantum_q[1] <= QUANTUM1_RST;
      quantum_q[2] <= QUANTUM2_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_idx)
        CFG_QUANTUM0: quantum_q[0] <= cfg_i.data.wdata;
        CFG_QUANTUM1: quantum_q[1] <= cfg_i.data.wdata;
        CFG_QUANTUM2: quantum_q[2] <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // read state is left in the following cycle and always ends in a running grant
  a_read_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_IDLE && run_valid_q)
    else $error("pop read did not complete into a running grant");

  a_no_accept_in_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !acc && out_load)
    else $error("request taken while a pop read is pending");

  a_running_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> proc_cnt_q != '0)
    else $error("running process not counted in the process total");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> nonempty != '0 && !run_valid_q)
    else $error("pop issued with empty queues or a process running");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_cnt_q <= MaxCnt)
    else $error("process total above the bound");

endmodule

[test/tb.sv]
// Testbench for the multilevel feedback queue scheduler core: directed table,
// then randomized add/dispatch/report traffic checked against a local predictor.
// Depends on mfqs_pkg, mfqs_stream_if and multilevel_feedback_queue_scheduler_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfqs_pkg::*;

  localparam int MAX_PROCS      = 32;
  localparam int PID_BITS       = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // func code 3 has no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {PACE_STEADY, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;

  // one directed row: request, flag for a hand-typed response, that response
  typedef struct packed {
    logic                  typed;
    logic [1:0]            func;
    logic [PID_PORT_W-1:0] pid;
    logic                  fin;
    logic                  io;
    logic [PID_PORT_W-1:0] g_pid;
    logic [1:0]            g_lvl;
    logic [QUANTUM_W-1:0]  g_q;
    logic [1:0]            st;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    // empty scheduler: nothing ready, nothing running, unused func
    '{1'b1, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0000, LVL0, 8'd0, STATUS_NONE_READY},
    '{1'b1, FUNC_REPORT,   16'h0000, 1'b1, 1'b1, 16'h0000, LVL0, 8'd0, STATUS_NOT_RUN},
    '{1'b1, FUNC_UNUSED,   16'hFFFF, 1'b1, 1'b1, 16'h0000, LVL0, 8'd0, STATUS_OK},
    // extreme ids; report bits ignored on add
    '{1'b1, FUNC_ADD,      16'hFFFF, 1'b1, 1'b1, 16'h0000, LVL0, 8'd0, STATUS_OK},
    '{1'b1, FUNC_ADD,      16'h0000, 1'b0, 1'b0, 16'h0000, LVL0, 8'd0, STATUS_OK},
    // grant at reset quantum, then re-grant while running
    '{1'b1, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'hFFFF, LVL0, QUANTUM0_RST, STATUS_OK},
    '{1'b1, FUNC_DISPATCH, 16'h1234, 1'b1, 1'b1, 16'hFFFF, LVL0, QUANTUM0_RST, STATUS_OK},
    // I/O on level 0 stays on level 0
    '{1'b1, FUNC_REPORT,   16'hAAAA, 1'b0, 1'b1, 16'h0000, LVL0, 8'd0, STATUS_OK},
    '{1'b1, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0000, LVL0, QUANTUM0_RST, STATUS_OK},
    // walk one id down through every level, back up to level 1 and down again
    '{1'b0, FUNC_REPORT,   16'h5555, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'h0000, 1'b1, 1'b1, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'h0000, 1'b0, 1'b1, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_DISPATCH, 16'h0000, 1'b0, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b0, FUNC_REPORT,   16'hFFFF, 1'b1, 1'b0, 16'h0, LVL0, 8'd0, STATUS_OK},
    '{1'b1, FUNC_DISPATCH, 16'h5A5A, 1'b1, 1'b0, 16'h0000, LVL0, 8'd0, STATUS_NONE_READY}
  };

  logic clk;
  logic rst_n;

  mfqs_stream_if #(.T(req_t)) req_if ();
  mfqs_stream_if #(.T(rsp_t)) rsp_if ();
  mfqs_stream_if #(.T(cfg_t)) cfg_if ();

  multilevel_feedback_queue_scheduler_core #(
    .MAX_PROCS(MAX_PROCS),
    .PID_BITS (PID_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // scheduler shadow state
  logic [PID_PORT_W-1:0] ring_mem [NUM_LEVELS][MAX_PROCS];
  int                    ring_head [NUM_LEVELS];
  int                    ring_count [NUM_LEVELS];
  int                    proc_count;
  logic [PID_PORT_W-1:0] run_pid;
  logic [1:0]            run_lvl;
  bit                    run_valid;
  logic [QUANTUM_W-1:0]  quantum [NUM_LEVELS] = '{QUANTUM0_RST, QUANTUM1_RST, QUANTUM2_RST};

  rsp_t expected_grants [$];
  rsp_t want_rsp;
  int   errors;
  int   idle_pct;
  int   stall_pct;
  int   hold_left;
  bit   hold_req;
  int   quiet_cycles;

  function automatic void ring_push(input logic [1:0] lvl, input logic [PID_PORT_W-1:0] pid);
    if (ring_count[lvl] < MAX_PROCS) begin
      ring_mem[lvl][(ring_head[lvl] + ring_count[lvl]) % MAX_PROCS] = pid;
      ring_count[lvl]++;
    end
  endfunction

  // Applies one request to the shadow state and returns the response it earns.
  function automatic rsp_t schedule_request(input req_t r);
    rsp_t       o;
    logic [1:0] dest;
    int         lv;
    bit         found;
    o = '0;
    o.status = STATUS_OK;
    case (r.func)
      FUNC_ADD: begin
        if (proc_count >= MAX_PROCS) begin
          o.status = STATUS_TABLE_FULL;
        end else begin
          ring_push(LVL0, r.new_pid);
          proc_count++;
        end
      end
      FUNC_DISPATCH: begin
        found = 1'b0;
        if (!run_valid) begin
          // highest-priority non-empty level wins
          for (lv = 0; lv < NUM_LEVELS && !found; lv++) begin
            if (ring_count[lv] != 0) begin
              found = 1'b1;
              run_pid = ring_mem[lv][ring_head[lv]];
              ring_head[lv] = (ring_head[lv] + 1) % MAX_PROCS;
              ring_count[lv]--;
              run_lvl = lv[1:0];
              run_valid = 1'b1;
            end
          end
        end
        if (run_valid) begin
          o.granted_pid     = run_pid;
          o.granted_level   = run_lvl;
          o.granted_quantum = quantum[run_lvl];
        end else begin
          o.status = STATUS_NONE_READY;
        end
      end
      FUNC_REPORT: begin
        if (!run_valid) begin
          o.status = STATUS_NOT_RUN;
        end else begin
          if (r.finished) begin
            if (proc_count > 0) proc_count--;
          end else begin
            if (r.did_io) dest = (run_lvl == LVL2) ? LVL1 : LVL0;
            else          dest = (run_lvl == LVL0) ? LVL1 : LVL2;
            ring_push(dest, run_pid);
          end
          run_valid = 1'b0;
          run_pid   = '0;
          run_lvl   = LVL0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t rand_req(input logic [1:0] f);
    req_t r;
    r.func     = f;
    r.new_pid  = PID_PORT_W'($urandom);
    r.finished = 1'($urandom_range(0, 1));
    r.did_io   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a falling edge, returns at a falling edge after the transaction.
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    predicted = schedule_request(r);
    expected_grants.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding response come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_quanta(input logic [QUANTUM_W-1:0] q0, q1, q2);
    logic [QUANTUM_W-1:0] vals [NUM_LEVELS];
    logic [1:0]           idx [NUM_LEVELS];
    int                   i;
    vals = '{q0, q1, q2};
    idx  = '{CFG_QUANTUM0, CFG_QUANTUM1, CFG_QUANTUM2};
    for (i = 0; i < NUM_LEVELS; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= '{reg_idx: idx[i], wdata: vals[i]};
      do @(posedge clk); while (!cfg_if.ready);
      quantum[idx[i]] = vals[i];
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly dispatch/report pairs, with add bursts deep enough to fill the
  // process table, plus loose requests of any func.
  task automatic run_random(input int target, input bit squeeze);
    int   sent;
    int   kind;
    int   k;
    int   j;
    bit   held;
    sent = 0;
    held = 1'b0;
    while (sent < target) begin
      if (squeeze && !held && sent >= 30) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
        k = $urandom_range(8, 40);
        for (j = 0; j < k; j++) send_req(rand_req(FUNC_ADD), 1'b0, '0);
        sent += k;
      end else if (kind <= 6) begin
        send_req(rand_req(FUNC_DISPATCH), 1'b0, '0);
        sent++;
        if ($urandom_range(0, 3) == 0) begin
          send_req(rand_req(FUNC_DISPATCH), 1'b0, '0);
          sent++;
        end
        send_req(rand_req(FUNC_REPORT), 1'b0, '0);
        sent++;
      end else if (kind == 7) begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) send_req(rand_req(FUNC_ADD), 1'b0, '0);
        sent += k;
      end else begin
        send_req(rand_req(2'($urandom_range(0, 3))), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // Response side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every response transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %h", $time, rsp_if.data);
        errors++;
      end else begin
        want_rsp = expected_grants.pop_front();
        check_field("granted_pid", want_rsp.granted_pid, rsp_if.data.granted_pid);
        check_field("granted_level", 16'(want_rsp.granted_level),
                    16'(rsp_if.data.granted_level));
        check_field("granted_quantum", 16'(want_rsp.granted_quantum),
                    16'(rsp_if.data.granted_quantum));
        check_field("status", 16'(want_rsp.status), 16'(rsp_if.data.status));
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : main_seq
    int       i;
    int       p;
    pace_e    pace;
    req_t     r;
    rsp_t     w;
    dir_row_t row;
    errors       = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    hold_req     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table at reset quanta, no idling
    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      r = '{func: row.func, new_pid: row.pid, finished: row.fin, did_io: row.io};
      w = '{granted_pid: row.g_pid, granted_level: row.g_lvl,
            granted_quantum: row.g_q, status: row.st};
      send_req(r, row.typed, w);
    end

    // one random phase per pacing mode, each with its own quanta
    for (p = 0; p < 4; p++) begin
      pace = pace_e'(p);
      case (pace)
        PACE_STEADY:    begin idle_pct = 0;  stall_pct = 0;  end
        PACE_SRC_IDLE:  begin idle_pct = 76; stall_pct = 0;  end
        PACE_SNK_STALL: begin idle_pct = 0;  stall_pct = 76; end
        default:        begin idle_pct = 17; stall_pct = 17; end
      endcase
      wait_idle();
      case (pace)
        PACE_STEADY:    write_quanta(8'd255, 8'd255, 8'd255);
        PACE_SRC_IDLE:  write_quanta(8'd1, 8'd1, 8'd1);
        PACE_SNK_STALL: write_quanta(8'd0, 8'd7, 8'd255);
        default: write_quanta(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                              8'($urandom_range(1, 255)));
      endcase
      run_random(95, pace == PACE_STEADY);
    end

    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
